[sv/mpsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shelf atlas allocator package
// Shared widths, defaults, status codes and register indexes.
// ----------------------------------------------------------------------------
package mpsa_pkg;

	localparam int ATLAS_DIM_DEF     = 2048;
	localparam int MAX_PAGES_DEF     = 8;
	localparam int MAX_GLYPH_DIM_DEF = 512;

	localparam int GLYPH_W    = 10;
	localparam int GUTTER_W   = 4;
	localparam int LIMIT_W    = 4;
	localparam int CFG_DATA_W = 4;
	localparam int COUNT_W    = 16;
	localparam int POS_W      = 11;
	localparam int PAGE_W     = 3;
	localparam int TOTAL_W    = 32;
	localparam int STATUS_W   = 3;

	localparam logic [GUTTER_W-1:0] GUTTER_RESET = 4'd1;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 4'd8;
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

	typedef enum logic [STATUS_W-1:0] {
		ST_PLACED    = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NO_PIXELS = 3'd2,
		ST_NO_PAGE   = 3'd3,
		ST_CLEARED   = 3'd4
	} status_t;

	typedef enum logic {
		CFG_GUTTER     = 1'b0,
		CFG_PAGE_LIMIT = 1'b1
	} cfg_index_t;

endpackage

[sv/mpsa_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shelf atlas allocator channels
// Request channel (glyph rectangle or clear) and placement result channel.
// ----------------------------------------------------------------------------
interface mpsa_in_if;
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic [mpsa_pkg::GLYPH_W-1:0] glyph_width;
	logic [mpsa_pkg::GLYPH_W-1:0] glyph_height;
	logic                         has_pixels;
	logic                         new_page_ok;

	modport source (output valid, cmd, glyph_width, glyph_height, has_pixels, new_page_ok,
		input ready);
	modport sink (input valid, cmd, glyph_width, glyph_height, has_pixels, new_page_ok,
		output ready);
endinterface

interface mpsa_out_if;
	logic                          valid;
	logic                          ready;
	logic [mpsa_pkg::STATUS_W-1:0] status;
	logic [mpsa_pkg::PAGE_W-1:0]   page;
	logic [mpsa_pkg::POS_W-1:0]    pos_x;
	logic [mpsa_pkg::POS_W-1:0]    pos_y;
	logic                          evicted;
	logic [mpsa_pkg::PAGE_W-1:0]   evicted_page;
	logic [mpsa_pkg::COUNT_W-1:0]  dropped_glyphs;
	logic [mpsa_pkg::TOTAL_W-1:0]  eviction_total;

	modport source (output valid, status, page, pos_x, pos_y, evicted, evicted_page,
		dropped_glyphs, eviction_total, input ready);
	modport sink (input valid, status, page, pos_x, pos_y, evicted, evicted_page,
		dropped_glyphs, eviction_total, output ready);
endinterface

[sv/mpsa_page_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page state memory
// One entry per page (cursor x, cursor y, row height, glyph count);
// one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mpsa_page_mem #(
	parameter int DEPTH = mpsa_pkg::MAX_PAGES_DEF,
	parameter int DW    = 1,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data_q <= mem_q[raddr];
	end

	assign rd_data = rd_data_q;

endmodule

[sv/mpsa_fit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shelf fit unit
// Checks one page entry for room in the current row or a new row, or
// starts from a fresh page, and builds the updated entry for the placement.
// ----------------------------------------------------------------------------
module mpsa_fit #(
	parameter int ATLAS_DIM = mpsa_pkg::ATLAS_DIM_DEF,
	localparam int CW       = $clog2(ATLAS_DIM + 1),
	localparam int RW       = mpsa_pkg::GLYPH_W
) (
	input  logic                          wipe,
	input  logic [CW-1:0]                 cx,
	input  logic [CW-1:0]                 cy,
	input  logic [RW-1:0]                 rh,
	input  logic [mpsa_pkg::COUNT_W-1:0]  cnt,
	input  logic [RW-1:0]                 w,
	input  logic [RW-1:0]                 h,
	input  logic [mpsa_pkg::GUTTER_W-1:0] gutter,
	output logic                          ok,
	output logic [CW-1:0]                 pos_x,
	output logic [CW-1:0]                 pos_y,
	output logic [CW-1:0]                 nx,
	output logic [CW-1:0]                 ny,
	output logic [RW-1:0]                 nrh,
	output logic [mpsa_pkg::COUNT_W-1:0]  ncnt
);

	localparam int SW = CW + 2;

	logic [SW-1:0] lim, cx_e, cy_e, rh_e, w_e, h_e, g_e;
	logic [SW-1:0] row_x_end, row_y_end, below, new_end, nx_sum;
	logic          row_fit, new_fit;
	logic [CW-1:0] bx, by, g_c;
	logic [RW-1:0] brh;
	logic [mpsa_pkg::COUNT_W-1:0] bcnt;

	assign lim  = SW'(ATLAS_DIM);
	assign cx_e = SW'(cx);
	assign cy_e = SW'(cy);
	assign rh_e = SW'(rh);
	assign w_e  = SW'(w);
	assign h_e  = SW'(h);
	assign g_e  = SW'(gutter);
	assign g_c  = CW'(gutter);

	assign row_x_end = cx_e + w_e + g_e;
	assign row_y_end = cy_e + h_e + g_e;
	assign below     = cy_e + rh_e + g_e;
	assign new_end   = below + h_e + g_e;
	assign row_fit   = (row_x_end <= lim) && (row_y_end <= lim);
	assign new_fit   = (new_end <= lim);

	always_comb begin
		bx   = cx;
		by   = cy;
		brh  = rh;
		bcnt = cnt;
		ok   = 1'b0;
		if (wipe) begin
			bx   = g_c;
			by   = g_c;
			brh  = '0;
			bcnt = '0;
			ok   = 1'b1;
		end else if (row_fit) begin
			ok = 1'b1;
		end else if (new_fit) begin
			// open a row below the tallest item of the current one
			bx  = g_c;
			by  = below[CW-1:0];
			brh = '0;
			ok  = 1'b1;
		end
	end

	assign nx_sum = SW'(bx) + w_e + g_e;
	assign pos_x  = bx;
	assign pos_y  = by;
	assign nx     = nx_sum[CW-1:0];
	assign ny     = by;
	assign nrh    = (h > brh) ? h : brh;
	assign ncnt   = (bcnt == mpsa_pkg::COUNT_MAX) ? bcnt : bcnt + 1'b1;

endmodule

[sv/multi_page_shelf_atlas_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-page shelf atlas allocator
// Places glyph rectangles on square atlas pages with shelf packing,
// opening new pages or evicting the oldest one in round-robin order.
// ----------------------------------------------------------------------------
// One item is worked at a time. A clear, an empty glyph, a glyph without
// pixels or an oversized glyph goes straight from idle to the done state. A
// placement walks the open pages in order through the page memory, one page
// per cycle; a glyph that fits none of them opens a new page or, failing
// that, evicts the oldest open page. The result sits in an output register,
// so the next item is taken while a result waits there.
// ----------------------------------------------------------------------------
module multi_page_shelf_atlas_allocator #(
	parameter int ATLAS_DIM     = mpsa_pkg::ATLAS_DIM_DEF,
	parameter int MAX_PAGES     = mpsa_pkg::MAX_PAGES_DEF,
	parameter int MAX_GLYPH_DIM = mpsa_pkg::MAX_GLYPH_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  mpsa_pkg::cfg_index_t            wr_index,
	input  logic [mpsa_pkg::CFG_DATA_W-1:0] wr_data,
	mpsa_in_if.sink                         glyph,
	mpsa_out_if.source                      result
);

	localparam int CW  = $clog2(ATLAS_DIM + 1);
	localparam int SW  = CW + 2;
	localparam int RW  = mpsa_pkg::GLYPH_W;
	localparam int NW  = mpsa_pkg::COUNT_W;
	localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int PCW = $clog2(MAX_PAGES + 1);
	localparam int LW  = (PCW > mpsa_pkg::LIMIT_W) ? PCW : mpsa_pkg::LIMIT_W;
	localparam int EW  = 2 * CW + RW + NW;
	localparam int OW  = mpsa_pkg::POS_W;
	localparam int GW  = mpsa_pkg::PAGE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MISS,
		S_EVICT,
		S_DONE
	} state_t;

	state_t state_q;

	logic [mpsa_pkg::GUTTER_W-1:0] gutter_q;
	logic [mpsa_pkg::LIMIT_W-1:0]  limit_q;
	logic [PCW-1:0]                open_q;
	logic [PW-1:0]                 oldest_q;
	logic [mpsa_pkg::TOTAL_W-1:0]  evcnt_q;

	logic [RW-1:0] w_q, h_q;
	logic          newok_q;
	logic [PW-1:0] idx_q, ev_q;

	mpsa_pkg::status_t res_status_q;
	logic [PW-1:0]     res_page_q, res_evp_q;
	logic [CW-1:0]     res_px_q, res_py_q;
	logic              res_ev_q;
	logic [NW-1:0]     res_drop_q;

	logic                          out_valid_q;
	logic [mpsa_pkg::STATUS_W-1:0] out_status_q;
	logic [GW-1:0]                 out_page_q, out_evp_q;
	logic [OW-1:0]                 out_px_q, out_py_q;
	logic                          out_ev_q;
	logic [NW-1:0]                 out_drop_q;
	logic [mpsa_pkg::TOTAL_W-1:0]  out_total_q;
	logic                          out_load;

	logic          acc, empty, too_big, can_open, stale, more;
	logic [SW-1:0] w_in, h_in, g2;
	logic [LW-1:0] lim_req, lim_max, lim_eff;
	logic [PCW-1:0] idx_next;
	logic [PW-1:0] oldest_eff, ev_next;

	logic          mem_we;
	logic [PW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	logic          fit_wipe, fit_ok;
	logic [CW-1:0] fit_px, fit_py, fit_nx, fit_ny;
	logic [RW-1:0] fit_nrh;
	logic [NW-1:0] fit_ncnt;
	logic [CW-1:0] rd_cx, rd_cy;
	logic [RW-1:0] rd_rh;
	logic [NW-1:0] rd_cnt;

	logic [PW+GW-1:0] page_wide, evp_wide;
	logic [CW+OW-1:0] px_wide, py_wide;

	// request classification
	assign glyph.ready = (state_q == S_IDLE);
	assign acc         = glyph.valid && glyph.ready;
	assign w_in        = SW'(glyph.glyph_width);
	assign h_in        = SW'(glyph.glyph_height);
	assign g2          = SW'({gutter_q, 1'b0});
	assign empty       = (glyph.glyph_width == '0) || (glyph.glyph_height == '0);
	assign too_big     = (w_in > SW'(MAX_GLYPH_DIM)) || (h_in > SW'(MAX_GLYPH_DIM)) ||
		(w_in + g2 > SW'(ATLAS_DIM)) || (h_in + g2 > SW'(ATLAS_DIM));

	// page bookkeeping
	assign lim_req    = LW'(limit_q);
	assign lim_max    = LW'(MAX_PAGES);
	assign lim_eff    = (lim_req > lim_max) ? lim_max : lim_req;
	assign can_open   = (LW'(open_q) < lim_eff) && newok_q;
	assign stale      = (PCW'(oldest_q) >= open_q);
	assign oldest_eff = stale ? '0 : oldest_q;
	assign idx_next   = PCW'(idx_q) + 1'b1;
	assign more       = (idx_next < open_q);
	assign ev_next    = ((PCW'(ev_q) + 1'b1) == open_q) ? '0 : ev_q + PW'(1);

	// memory access
	always_comb begin
		case (state_q)
			S_SCAN:  raddr = idx_next[PW-1:0];
			S_MISS:  raddr = oldest_eff;
			default: raddr = '0;
		endcase
		case (state_q)
			S_SCAN:  waddr = idx_q;
			S_MISS:  waddr = open_q[PW-1:0];
			default: waddr = ev_q;
		endcase
	end

	assign mem_we = ((state_q == S_SCAN) && fit_ok) || ((state_q == S_MISS) && can_open) ||
		(state_q == S_EVICT);
	assign wdata  = {fit_nx, fit_ny, fit_nrh, fit_ncnt};

	assign rd_cx  = rdata[EW-1 -: CW];
	assign rd_cy  = rdata[EW-CW-1 -: CW];
	assign rd_rh  = rdata[RW+NW-1 -: RW];
	assign rd_cnt = rdata[NW-1:0];

	assign fit_wipe = (state_q != S_SCAN);

	mpsa_page_mem #(
		.DEPTH (MAX_PAGES),
		.DW    (EW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (raddr),
		.rd_data (rdata)
	);

	mpsa_fit #(
		.ATLAS_DIM (ATLAS_DIM)
	) u_fit (
		.wipe   (fit_wipe),
		.cx     (rd_cx),
		.cy     (rd_cy),
		.rh     (rd_rh),
		.cnt    (rd_cnt),
		.w      (w_q),
		.h      (h_q),
		.gutter (gutter_q),
		.ok     (fit_ok),
		.pos_x  (fit_px),
		.pos_y  (fit_py),
		.nx     (fit_nx),
		.ny     (fit_ny),
		.nrh    (fit_nrh),
		.ncnt   (fit_ncnt)
	);

	assign page_wide = {{GW{1'b0}}, res_page_q};
	assign evp_wide  = {{GW{1'b0}}, res_evp_q};
	assign px_wide   = {{OW{1'b0}}, res_px_q};
	assign py_wide   = {{OW{1'b0}}, res_py_q};

	// load the output register when it is empty or its beat leaves this cycle
	assign out_load = (state_q == S_DONE) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gutter_q    <= mpsa_pkg::GUTTER_RESET;
			limit_q     <= mpsa_pkg::LIMIT_RESET;
			open_q      <= '0;
			oldest_q    <= '0;
			evcnt_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					mpsa_pkg::CFG_GUTTER:     gutter_q <= wr_data;
					mpsa_pkg::CFG_PAGE_LIMIT: limit_q  <= wr_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (acc) begin
						w_q        <= glyph.glyph_width;
						h_q        <= glyph.glyph_height;
						newok_q    <= glyph.new_page_ok;
						idx_q      <= '0;
						res_page_q <= '0;
						res_px_q   <= '0;
						res_py_q   <= '0;
						res_ev_q   <= 1'b0;
						res_evp_q  <= '0;
						res_drop_q <= '0;
						if (glyph.cmd) begin
							open_q       <= '0;
							oldest_q     <= '0;
							evcnt_q      <= evcnt_q + 1'b1;
							res_status_q <= mpsa_pkg::ST_CLEARED;
							state_q      <= S_DONE;
						end else if (empty) begin
							res_status_q <= mpsa_pkg::ST_EMPTY;
							state_q      <= S_DONE;
						end else if (!glyph.has_pixels) begin
							res_status_q <= mpsa_pkg::ST_NO_PIXELS;
							state_q      <= S_DONE;
						end else if (too_big) begin
							res_status_q <= mpsa_pkg::ST_NO_PAGE;
							state_q      <= S_DONE;
						end else if (open_q != '0) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_MISS;
						end
					end
				end
				S_SCAN: begin
					if (fit_ok) begin
						res_status_q <= mpsa_pkg::ST_PLACED;
						res_page_q   <= idx_q;
						res_px_q     <= fit_px;
						res_py_q     <= fit_py;
						state_q      <= S_DONE;
					end else if (more) begin
						// next page was read this cycle
						idx_q <= idx_next[PW-1:0];
					end else begin
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					if (can_open) begin
						open_q       <= open_q + 1'b1;
						res_status_q <= mpsa_pkg::ST_PLACED;
						res_page_q   <= open_q[PW-1:0];
						res_px_q     <= fit_px;
						res_py_q     <= fit_py;
						state_q      <= S_DONE;
					end else if (open_q != '0) begin
						ev_q    <= oldest_eff;
						state_q <= S_EVICT;
					end else begin
						res_status_q <= mpsa_pkg::ST_NO_PAGE;
						state_q      <= S_DONE;
					end
				end
				S_EVICT: begin
					res_status_q <= mpsa_pkg::ST_PLACED;
					res_page_q   <= ev_q;
					res_px_q     <= fit_px;
					res_py_q     <= fit_py;
					res_ev_q     <= 1'b1;
					res_evp_q    <= ev_q;
					res_drop_q   <= rd_cnt;
					evcnt_q      <= evcnt_q + 1'b1;
					oldest_q     <= ev_next;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						out_status_q <= res_status_q;
						out_page_q   <= page_wide[GW-1:0];
						out_px_q     <= px_wide[OW-1:0];
						out_py_q     <= py_wide[OW-1:0];
						out_ev_q     <= res_ev_q;
						out_evp_q    <= evp_wide[GW-1:0];
						out_drop_q   <= res_drop_q;
						out_total_q  <= evcnt_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid          = out_valid_q;
	assign result.status         = out_status_q;
	assign result.page           = out_page_q;
	assign result.pos_x          = out_px_q;
	assign result.pos_y          = out_py_q;
	assign result.evicted        = out_ev_q;
	assign result.evicted_page   = out_evp_q;
	assign result.dropped_glyphs = out_drop_q;
	assign result.eviction_total = out_total_q;

`ifndef ASSERT_OFF
	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= PCW'(MAX_PAGES))
		else $error("open page count beyond page memory depth");

	a_oldest_range: assert property (@(posedge clk) disable iff (!arst_n)
		(PCW'(oldest_q) < open_q) || (oldest_q == '0))
		else $error("oldest page pointer outside the open pages");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SCAN || state_q == S_MISS || state_q == S_EVICT))
		else $error("page memory written outside a placement");

	a_evcnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (evcnt_q == $past(evcnt_q) || evcnt_q == $past(evcnt_q) + 1'b1))
		else $error("eviction count moved by more than one");

	a_evict_placed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ev_q) |-> (out_status_q == mpsa_pkg::ST_PLACED))
		else $error("eviction reported without a placement");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shelf atlas allocator testbench
// Feeds glyph rectangles and clears through the request channel, keeps a
// shadow copy of every page's shelf cursors, and compares each placement
// beat against the shadow's prediction. The run walks several gutter and
// page-limit settings under shifting back-pressure.
// ----------------------------------------------------------------------------
module tb;
	import mpsa_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 153;

	typedef struct {
		logic             cmd;
		logic [GLYPH_W-1:0] width;
		logic [GLYPH_W-1:0] height;
		logic             pix;
		logic             new_ok;
	} glyph_req_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [PAGE_W-1:0]   page;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic                evicted;
		logic [PAGE_W-1:0]   evicted_page;
		logic [COUNT_W-1:0]  dropped;
		logic [TOTAL_W-1:0]  total;
	} placement_t;

	// Shadow of the page shelves plus the placements still owed by the block.
	class atlas_shadow;
		int unsigned gutter;
		int unsigned limit;
		int unsigned shelf_x[MAX_PAGES_DEF];
		int unsigned shelf_y[MAX_PAGES_DEF];
		int unsigned row_h[MAX_PAGES_DEF];
		int unsigned page_glyphs[MAX_PAGES_DEF];
		int unsigned opened;
		int unsigned oldest;
		logic [TOTAL_W-1:0] evictions;
		placement_t placements_due[$];
		int errors;

		function new();
			gutter = 32'(GUTTER_RESET);
			limit = 32'(LIMIT_RESET);
			for (int i = 0; i < MAX_PAGES_DEF; i++) begin
				shelf_x[i] = 0;
				shelf_y[i] = 0;
				row_h[i] = 0;
				page_glyphs[i] = 0;
			end
			opened = 0;
			oldest = 0;
			evictions = '0;
			errors = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
			if (idx == CFG_GUTTER)
				gutter = 32'(v);
			else
				limit = 32'(v);
		endfunction

		function void wipe(int unsigned p);
			shelf_x[p] = gutter;
			shelf_y[p] = gutter;
			row_h[p] = 0;
			page_glyphs[p] = 0;
		endfunction

		// Current row first, then a new row under the tallest glyph of this one.
		function bit shelf_fits(int unsigned p, int unsigned w, int unsigned h);
			int unsigned below;
			if (shelf_x[p] + w + gutter <= ATLAS_DIM_DEF &&
				shelf_y[p] + h + gutter <= ATLAS_DIM_DEF)
				return 1'b1;
			below = shelf_y[p] + row_h[p] + gutter;
			if (below + h + gutter <= ATLAS_DIM_DEF) begin
				shelf_x[p] = gutter;
				shelf_y[p] = below;
				row_h[p] = 0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void take_request(glyph_req_t r);
			placement_t e;
			int unsigned w, h, lim, p;
			bit found;
			w = 32'(r.width);
			h = 32'(r.height);
			e.status = ST_NO_PAGE;
			e.page = '0;
			e.pos_x = '0;
			e.pos_y = '0;
			e.evicted = 1'b0;
			e.evicted_page = '0;
			e.dropped = '0;
			found = 1'b0;
			p = 0;
			if (r.cmd) begin
				opened = 0;
				oldest = 0;
				evictions++;
				e.status = ST_CLEARED;
			end else if (w == 0 || h == 0) begin
				e.status = ST_EMPTY;
			end else if (!r.pix) begin
				e.status = ST_NO_PIXELS;
			end else if (w > MAX_GLYPH_DIM_DEF || h > MAX_GLYPH_DIM_DEF ||
				w + 2 * gutter > ATLAS_DIM_DEF || h + 2 * gutter > ATLAS_DIM_DEF) begin
				e.status = ST_NO_PAGE;
			end else begin
				for (int i = 0; i < opened && i < MAX_PAGES_DEF && !found; i++) begin
					if (shelf_fits(i, w, h)) begin
						p = i;
						found = 1'b1;
					end
				end
				if (!found) begin
					lim = (limit < MAX_PAGES_DEF) ? limit : MAX_PAGES_DEF;
					if (opened < lim && r.new_ok) begin
						p = opened;
						wipe(p);
						opened++;
						found = 1'b1;
					end else if (opened > 0) begin
						if (oldest >= opened)
							oldest = 0;
						p = oldest;
						e.dropped = COUNT_W'(page_glyphs[p]);
						wipe(p);
						evictions++;
						e.evicted = 1'b1;
						e.evicted_page = PAGE_W'(p);
						oldest = (oldest + 1) % opened;
						found = 1'b1;
					end
				end
				if (found) begin
					e.status = ST_PLACED;
					e.page = PAGE_W'(p);
					e.pos_x = POS_W'(shelf_x[p]);
					e.pos_y = POS_W'(shelf_y[p]);
					shelf_x[p] += w + gutter;
					if (h > row_h[p])
						row_h[p] = h;
					if (page_glyphs[p] < COUNT_MAX)
						page_glyphs[p]++;
				end
			end
			e.total = evictions;
			placements_due = {placements_due, e};
		endfunction

		function void field_ok(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void match_placement(placement_t a);
			placement_t e;
			if (placements_due.size() == 0) begin
				$display("%0t: result beat with no request pending, status %0d", $time,
					a.status);
				errors++;
				return;
			end
			e = placements_due.pop_front();
			field_ok("status", 32'(e.status), 32'(a.status));
			field_ok("page", 32'(e.page), 32'(a.page));
			field_ok("pos_x", 32'(e.pos_x), 32'(a.pos_x));
			field_ok("pos_y", 32'(e.pos_y), 32'(a.pos_y));
			field_ok("evicted", 32'(e.evicted), 32'(a.evicted));
			field_ok("evicted_page", 32'(e.evicted_page), 32'(a.evicted_page));
			field_ok("dropped_glyphs", 32'(e.dropped), 32'(a.dropped));
			field_ok("eviction_total", e.total, a.total);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	cfg_index_t            wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	int unsigned src_idle;
	int unsigned snk_idle;
	atlas_shadow shadow;

	mpsa_in_if  gin ();
	mpsa_out_if gout ();

	multi_page_shelf_atlas_allocator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.glyph    (gin),
		.result   (gout)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic glyph_req_t req(logic c, int unsigned w, int unsigned h, logic px,
		logic ok);
		glyph_req_t r;
		r.cmd = c;
		r.width = GLYPH_W'(w);
		r.height = GLYPH_W'(h);
		r.pix = px;
		r.new_ok = ok;
		return r;
	endfunction

	// Mostly large rectangles so pages fill and evictions come early.
	function automatic logic [GLYPH_W-1:0] pick_dim();
		int unsigned k;
		k = $urandom_range(9);
		if (k < 6)
			return GLYPH_W'($urandom_range(MAX_GLYPH_DIM_DEF, 200));
		else if (k < 9)
			return GLYPH_W'($urandom_range(199, 16));
		return GLYPH_W'($urandom_range(15, 1));
	endfunction

	function automatic glyph_req_t random_glyph();
		glyph_req_t r;
		int unsigned k;
		k = $urandom_range(999);
		r.cmd = 1'b0;
		r.pix = 1'b1;
		r.new_ok = ($urandom_range(9) < 8);
		r.width = pick_dim();
		r.height = pick_dim();
		if (k < 15) begin
			r.cmd = 1'b1;
			r.width = GLYPH_W'($urandom);
			r.height = GLYPH_W'($urandom);
			r.pix = 1'($urandom);
			r.new_ok = 1'($urandom);
		end else if (k < 55) begin
			r.width = GLYPH_W'($urandom);
			r.height = GLYPH_W'($urandom);
			case ($urandom_range(2))
				0: r.width = '0;
				1: r.height = '0;
				default: begin
					r.width = '0;
					r.height = '0;
				end
			endcase
			r.pix = 1'($urandom);
		end else if (k < 95) begin
			r.pix = 1'b0;
		end else if (k < 125) begin
			if ($urandom_range(1))
				r.width = GLYPH_W'($urandom_range(1023, MAX_GLYPH_DIM_DEF + 1));
			else
				r.height = GLYPH_W'($urandom_range(1023, MAX_GLYPH_DIM_DEF + 1));
		end
		return r;
	endfunction

	task automatic push_glyph(glyph_req_t r);
		while ($urandom_range(99) < src_idle) begin
			gin.valid <= 1'b0;
			@(posedge clk);
		end
		gin.valid        <= 1'b1;
		gin.cmd          <= r.cmd;
		gin.glyph_width  <= r.width;
		gin.glyph_height <= r.height;
		gin.has_pixels   <= r.pix;
		gin.new_page_ok  <= r.new_ok;
		do
			@(posedge clk);
		while (!(gin.valid && gin.ready));
		shadow.take_request(r);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= v;
		@(posedge clk);
		shadow.set_reg(idx, v);
	endtask

	// Drop valid and wait until every placement beat has come back.
	task automatic settle();
		gin.valid <= 1'b0;
		while (shadow.placements_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(int unsigned gut, int unsigned lim, int unsigned mode);
		settle();
		write_reg(CFG_GUTTER, CFG_DATA_W'(gut));
		write_reg(CFG_PAGE_LIMIT, CFG_DATA_W'(lim));
		wr_en <= 1'b0;
		case (mode)
			0: begin
				src_idle = 29;
				snk_idle = 85;
			end
			1: begin
				src_idle = 85;
				snk_idle = 29;
			end
			default: begin
				src_idle = 0;
				snk_idle = 0;
			end
		endcase
		repeat (ITEMS_PER_PHASE) push_glyph(random_glyph());
	endtask

	// Result side: take beats under random stalls.
	initial begin
		placement_t got;
		gout.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (gout.valid === 1'b1 && gout.ready) begin
				got.status       = gout.status;
				got.page         = gout.page;
				got.pos_x        = gout.pos_x;
				got.pos_y        = gout.pos_y;
				got.evicted      = gout.evicted;
				got.evicted_page = gout.evicted_page;
				got.dropped      = gout.dropped_glyphs;
				got.total        = gout.eviction_total;
				shadow.match_placement(got);
			end
			gout.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((gin.valid && gin.ready) || (gout.valid === 1'b1 && gout.ready) || wr_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		shadow = new();
		src_idle = 0;
		snk_idle = 0;
		arst_n           <= 1'b0;
		wr_en            <= 1'b0;
		wr_index         <= CFG_GUTTER;
		wr_data          <= '0;
		gin.valid        <= 1'b0;
		gin.cmd          <= 1'b0;
		gin.glyph_width  <= '0;
		gin.glyph_height <= '0;
		gin.has_pixels   <= 1'b0;
		gin.new_page_ok  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: nothing open, so a glyph with no new page has nowhere to go.
		push_glyph(req(1'b0, 10, 10, 1'b1, 1'b0));
		push_glyph(req(1'b0, 0, 5, 1'b1, 1'b1));
		push_glyph(req(1'b0, 5, 0, 1'b0, 1'b0));
		push_glyph(req(1'b0, 0, 0, 1'b0, 1'b1));
		push_glyph(req(1'b1, 0, 0, 1'b0, 1'b0));
		push_glyph(req(1'b0, 20, 20, 1'b0, 1'b1));
		push_glyph(req(1'b0, 1023, 10, 1'b1, 1'b1));
		push_glyph(req(1'b0, 10, 513, 1'b1, 1'b1));
		push_glyph(req(1'b0, 512, 512, 1'b1, 1'b1));
		push_glyph(req(1'b0, 1, 1, 1'b1, 1'b1));
		push_glyph(req(1'b0, 512, 512, 1'b1, 1'b1));
		push_glyph(req(1'b0, 512, 512, 1'b1, 1'b1));
		push_glyph(req(1'b0, 512, 1, 1'b1, 1'b0));
		push_glyph(req(1'b0, 1, 512, 1'b1, 1'b1));
		push_glyph(req(1'b0, 512, 512, 1'b1, 1'b0));
		push_glyph(req(1'b0, 512, 512, 1'b1, 1'b1));
		push_glyph(req(1'b0, 512, 512, 1'b1, 1'b1));
		push_glyph(req(1'b0, 512, 512, 1'b1, 1'b1));
		push_glyph(req(1'b0, 512, 512, 1'b1, 1'b1));
		push_glyph(req(1'b1, 1023, 1023, 1'b1, 1'b1));
		push_glyph(req(1'b0, 512, 512, 1'b1, 1'b1));
		push_glyph(req(1'b0, 1023, 1023, 1'b0, 1'b0));

		run_phase(0, 1, 0);
		run_phase(15, 8, 1);
		run_phase(7, 2, 2);
		// Limit below the open count: open pages stay in rotation.
		run_phase(0, 0, 0);
		run_phase(15, 15, 1);
		run_phase(3, 1, 2);
		run_phase(0, 8, 0);
		run_phase(9, 4, 1);

		settle();
		repeat (20) @(posedge clk);
		if (shadow.errors == 0 && shadow.placements_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[multi_page_shelf_atlas_allocator.f]
sv/mpsa_pkg.sv
sv/mpsa_if.sv
sv/mpsa_page_mem.sv
sv/mpsa_fit.sv
sv/multi_page_shelf_atlas_allocator.sv
tb/tb.sv
